FILE: src/four_digit_segment_writer_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef FOUR_DIGIT_SEGMENT_WRITER_UNIT_DEFINES_SVH
`define FOUR_DIGIT_SEGMENT_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define FDSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fdsw check failed");

// Next-cycle implication, quiet during reset.
`define FDSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fdsw check failed");

`endif

FILE: src/fdsw_pkg.sv
`default_nettype none

package fdsw_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int VALUE_W     = 14;
    localparam int SEG_W       = 7;
    localparam int GRID_W      = 7;

    localparam logic [VALUE_W-1:0] MAX_SHOWN = 14'd9999;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [SEG_W-1:0]   seg_t;
    typedef logic [GRID_W-1:0]  grid_t;
    typedef logic [1:0]         beat_t;
    typedef logic [3:0]         digit_t;
    typedef seg_t               seg_row_t [DIGIT_COUNT];

    localparam grid_t GRID_THOUSANDS = 7'h68;
    localparam grid_t GRID_HUNDREDS  = 7'h6A;
    localparam grid_t GRID_TENS      = 7'h6C;
    localparam grid_t GRID_UNITS     = 7'h6E;

    localparam beat_t BEAT_THOUSANDS = 2'd0;
    localparam beat_t BEAT_HUNDREDS  = 2'd1;
    localparam beat_t BEAT_TENS      = 2'd2;
    localparam beat_t BEAT_UNITS     = 2'd3;

    localparam seg_t SEG_0 = 7'h3F;
    localparam seg_t SEG_1 = 7'h06;
    localparam seg_t SEG_2 = 7'h5B;
    localparam seg_t SEG_3 = 7'h4F;
    localparam seg_t SEG_4 = 7'h66;
    localparam seg_t SEG_5 = 7'h6D;
    localparam seg_t SEG_6 = 7'h7D;
    localparam seg_t SEG_7 = 7'h07;
    localparam seg_t SEG_8 = 7'h7F;
    localparam seg_t SEG_9 = 7'h6F;

    // Common-cathode font, segment a in bit 0.
    function automatic seg_t seg_of(digit_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = SEG_0;
            4'd1:    s = SEG_1;
            4'd2:    s = SEG_2;
            4'd3:    s = SEG_3;
            4'd4:    s = SEG_4;
            4'd5:    s = SEG_5;
            4'd6:    s = SEG_6;
            4'd7:    s = SEG_7;
            4'd8:    s = SEG_8;
            default: s = SEG_9;
        endcase
        return s;
    endfunction

    function automatic grid_t grid_of(beat_t b);
        grid_t g;
        unique case (b)
            BEAT_THOUSANDS: g = GRID_THOUSANDS;
            BEAT_HUNDREDS:  g = GRID_HUNDREDS;
            BEAT_TENS:      g = GRID_TENS;
            default:        g = GRID_UNITS;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: src/fdsw_digit_split.sv
`default_nettype none

module fdsw_digit_split (
    input  fdsw_pkg::value_t   value,
    output fdsw_pkg::seg_row_t seg_row
);
    import fdsw_pkg::*;

    typedef struct packed {
        digit_t digit;
        value_t rem;
    } place_split_t;

    // Pick the largest multiple of place not above v; compares are independent.
    function automatic place_split_t split_place(value_t v, int place);
        place_split_t r;
        value_t       sub;
        r.digit = '0;
        sub     = '0;
        for (int k = 1; k < 10; k++) begin
            if (v >= VALUE_W'(k * place)) begin
                r.digit = 4'(k);
                sub     = VALUE_W'(k * place);
            end
        end
        r.rem = v - sub;
        return r;
    endfunction

    value_t       sat;
    place_split_t th;
    place_split_t hu;
    place_split_t te;

    always_comb begin
        sat = (value > MAX_SHOWN) ? MAX_SHOWN : value;
        th  = split_place(sat, 1000);
        hu  = split_place(th.rem, 100);
        te  = split_place(hu.rem, 10);
        seg_row[BEAT_THOUSANDS] = seg_of(th.digit);
        seg_row[BEAT_HUNDREDS]  = seg_of(hu.digit);
        seg_row[BEAT_TENS]      = seg_of(te.digit);
        seg_row[BEAT_UNITS]     = seg_of(te.rem[3:0]);
    end

endmodule

`default_nettype wire

FILE: src/fdsw_write_serializer.sv
`default_nettype none

module fdsw_write_serializer (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 load,
    input  fdsw_pkg::seg_row_t  seg_row,
    output logic                free,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output fdsw_pkg::grid_t     grid_address,
    output fdsw_pkg::seg_t      segment_pattern,
    output logic                m_tlast
);
    import fdsw_pkg::*;

    logic     busy_reg;
    logic     busy_next;
    beat_t    beat_reg;
    beat_t    beat_next;
    seg_row_t pat_reg;
    logic     last_taken;

    assign m_tvalid        = busy_reg;
    assign m_tlast         = (beat_reg == BEAT_UNITS);
    assign grid_address    = grid_of(beat_reg);
    assign segment_pattern = pat_reg[beat_reg];
    assign last_taken      = busy_reg && m_tready && m_tlast;
    assign free            = !busy_reg || last_taken;

    always_comb begin
        busy_next = busy_reg;
        beat_next = beat_reg;
        if (load) begin
            busy_next = 1'b1;
            beat_next = BEAT_THOUSANDS;
        end else if (last_taken) begin
            busy_next = 1'b0;
        end else if (busy_reg && m_tready) begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_THOUSANDS;
        end else begin
            busy_reg <= busy_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pat_reg <= seg_row;
        end
    end

endmodule

`default_nettype wire

FILE: src/four_digit_segment_writer_unit.sv
// Channel   Dir  Handshake          Payload
// s_ (in)   in   s_tvalid/s_tready  s_tdata[13:0] value
// m_ (out)  out  m_tvalid/m_tready  m_tdata grid_address, segment_pattern; m_tlast
//
// Each value yields four output transfers (thousands, hundreds, tens, units),
// so the sustained rate is set by the single output port.
// A value passes the input register and then the serializer registers before its first output transfer.
// A second value is taken into the input register while the current one drains.
// Reset (aresetn low, synchronous) drops both held items; stalls on m_ hold all.
`default_nettype none

module four_digit_segment_writer_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [13:0] value, [15:14] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [6:0] grid_address, [13:7] segment_pattern, [15:14] zero
    output logic        m_tlast    // last_write: units digit transfer
);
    import fdsw_pkg::*;

    logic     in_valid_reg;
    value_t   in_value_reg;
    logic     ser_free;
    logic     ser_load;
    seg_row_t seg_row;
    grid_t    grid_address;
    seg_t     segment_pattern;

    // Hand the held value on once the serializer finishes or is empty.
    assign ser_load = in_valid_reg && ser_free;
    assign s_tready = !in_valid_reg || ser_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (ser_load) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Capture the value on each input transfer.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_value_reg <= s_tdata[VALUE_W-1:0];
        end
    end

    // Saturate and split into four segment patterns.
    fdsw_digit_split u_split (
        .value   (in_value_reg),
        .seg_row (seg_row)
    );

    // Result register: walk the four grid writes.
    fdsw_write_serializer u_ser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (ser_load),
        .seg_row         (seg_row),
        .free            (ser_free),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .grid_address    (grid_address),
        .segment_pattern (segment_pattern),
        .m_tlast         (m_tlast)
    );

    assign m_tdata = {2'b00, segment_pattern, grid_address};

endmodule

`default_nettype wire

FILE: src/fdsw_port_checker.sv
`default_nettype none
`include "four_digit_segment_writer_unit_defines.svh"

module fdsw_port_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [15:0] m_tdata,
    input wire        m_tlast
);
    import fdsw_pkg::*;

    logic  xfer;
    logic  stall;
    logic  thousands_xfer;
    logic  hundreds_shown;
    logic  font_ok;
    grid_t grid;
    seg_t  pat;

    assign xfer           = m_tvalid && m_tready;
    assign stall          = m_tvalid && !m_tready;
    assign grid           = m_tdata[6:0];
    assign pat            = m_tdata[13:7];
    assign thousands_xfer = xfer && (grid == GRID_THOUSANDS);
    assign hundreds_shown = m_tvalid && (grid == GRID_HUNDREDS);
    assign font_ok        = (pat == SEG_0) || (pat == SEG_1) || (pat == SEG_2) ||
                            (pat == SEG_3) || (pat == SEG_4) || (pat == SEG_5) ||
                            (pat == SEG_6) || (pat == SEG_7) || (pat == SEG_8) ||
                            (pat == SEG_9);

    `FDSW_ASSERT_NEXT(a_hold_on_stall, stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `FDSW_ASSERT_NOW(a_last_on_units, m_tvalid, m_tlast == (grid == GRID_UNITS))
    `FDSW_ASSERT_NEXT(a_thousands_then_hundreds, thousands_xfer, hundreds_shown)
    `FDSW_ASSERT_NOW(a_legal_font, m_tvalid, font_ok)

endmodule

bind four_digit_segment_writer_unit fdsw_port_checker u_fdsw_port_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
